FILE: src/adagrad_parameter_update_unit_macros.svh
// Assertion macros used by the value stage RTL of the parameter update unit.
`ifndef ADAGRAD_PARAMETER_UPDATE_UNIT_MACROS_SVH
`define ADAGRAD_PARAMETER_UPDATE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define APU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define APU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define APU_ASSERT(name, prop, msg)
`define APU_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: src/apu_pkg.sv
package apu_pkg;

  localparam int NUM_VARS = 1024;
  localparam int IDX_W    = 10;
  localparam int GRAD_W   = 24;
  localparam int MAG_W    = 24;
  localparam int VAL_W    = 32;
  localparam int SUM_W    = 48;
  localparam int LR_W     = 24;
  localparam int EPS_W    = 16;
  localparam int PROD_W   = LR_W + MAG_W;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int ROOT_STAGES = ROOT_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int DEN_W    = ROOT_W + 1;
  localparam int Q_W      = 18;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STABILITY_OFFSET = 1'd1;

  localparam logic [LR_W-1:0]  LR_RESET  = 24'd16777;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd43;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Item context that rides along the root and divide pipelines.
  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  idx;
    logic              neg;
    logic [VAL_W-1:0]  init;
    logic              sat;
    logic [PROD_W-1:0] prod;
  } tag_t;

endpackage

FILE: src/apu_sum_stage.sv
module apu_sum_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        in_load,
  input  logic [apu_pkg::IDX_W-1:0]   in_idx,
  input  logic [apu_pkg::GRAD_W-1:0]  in_grad,
  input  logic [apu_pkg::VAL_W-1:0]   in_init,
  input  logic [apu_pkg::LR_W-1:0]    learning_rate,
  input  logic [apu_pkg::EPS_W-1:0]   stability_offset,
  output logic                        out_valid,
  output logic [apu_pkg::RAD_W-1:0]   out_rad,
  output apu_pkg::tag_t               out_tag
);
  import apu_pkg::*;

  logic [SUM_W-1:0] sum_mem [NUM_VARS];

  logic [MAG_W-1:0] in_mag;
  logic [SUM_W-1:0] in_sq;

  logic             s1_valid;
  logic             s1_load;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_neg;
  logic [MAG_W-1:0] s1_mag;
  logic [VAL_W-1:0] s1_init;
  logic [SUM_W-1:0] s1_sq;
  logic [SUM_W-1:0] rdata;
  logic             hit;
  logic [SUM_W-1:0] hit_val;

  logic [SUM_W-1:0] base;
  logic [SUM_W:0]   total;
  logic             ovf;
  logic [SUM_W-1:0] sum_new;
  logic [SUM_W:0]   biased;

  assign in_mag = in_grad[GRAD_W-1] ? (~in_grad + 1'b1) : in_grad;
  assign in_sq  = in_mag * in_mag;

  assign base    = hit ? hit_val : rdata;
  assign total   = {1'b0, base} + {1'b0, s1_sq};
  assign ovf     = total[SUM_W];
  assign sum_new = s1_load ? '0 : (ovf ? {SUM_W{1'b1}} : total[SUM_W-1:0]);
  assign biased  = {1'b0, sum_new} + (SUM_W+1)'(stability_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      // The entry written this cycle is newer than what the read returns.
      hit       <= s1_valid && (s1_idx == in_idx);
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_load <= in_load;
      s1_idx  <= in_idx;
      s1_neg  <= in_grad[GRAD_W-1];
      s1_mag  <= in_mag;
      s1_init <= in_init;
      s1_sq   <= in_sq;
      rdata   <= sum_mem[in_idx];
      hit_val <= sum_new;
      out_rad <= {{(RAD_W-SUM_W-15){1'b0}}, biased, 14'd0};
      out_tag.load <= s1_load;
      out_tag.idx  <= s1_idx;
      out_tag.neg  <= s1_neg;
      out_tag.init <= s1_init;
      out_tag.sat  <= ovf && !s1_load;
      out_tag.prod <= learning_rate * s1_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      sum_mem[s1_idx] <= sum_new;
    end
  end

endmodule

FILE: src/apu_sqrt.sv
module apu_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [apu_pkg::RAD_W-1:0]  in_rad,
  input  apu_pkg::tag_t              in_tag,
  output logic                       out_valid,
  output logic [apu_pkg::ROOT_W-1:0] out_root,
  output apu_pkg::tag_t              out_tag
);
  import apu_pkg::*;

  // One result bit per stage, most significant first.
  logic             vs [ROOT_STAGES];
  logic [RAD_W-1:0] xs [ROOT_STAGES];
  logic [RAD_W-1:0] rs [ROOT_STAGES];
  tag_t             ts [ROOT_STAGES];

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
    logic             vi;
    logic [RAD_W-1:0] xi;
    logic [RAD_W-1:0] ri;
    tag_t             ti;
    logic [RAD_W-1:0] bitv;
    logic [RAD_W-1:0] trial;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_rad;
      assign ri = '0;
      assign ti = in_tag;
    end else begin : g_next
      assign vi = vs[k-1];
      assign xi = xs[k-1];
      assign ri = rs[k-1];
      assign ti = ts[k-1];
    end

    assign bitv  = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    assign trial = ri + bitv;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ts[k] <= ti;
        if (xi >= trial) begin
          xs[k] <= xi - trial;
          rs[k] <= (ri >> 1) + bitv;
        end else begin
          xs[k] <= xi;
          rs[k] <= ri >> 1;
        end
      end
    end
  end

  assign out_valid = vs[ROOT_STAGES-1];
  assign out_root  = rs[ROOT_STAGES-1][ROOT_W-1:0];
  assign out_tag   = ts[ROOT_STAGES-1];

endmodule

FILE: src/apu_div.sv
module apu_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [apu_pkg::ROOT_W-1:0] in_root,
  input  apu_pkg::tag_t              in_tag,
  output logic                       out_valid,
  output logic [apu_pkg::Q_W-1:0]    out_q,
  output logic                       out_zero,
  output apu_pkg::tag_t              out_tag
);
  import apu_pkg::*;

  localparam int CMP_W = DEN_W + Q_W;

  // Entry register: numerator rounds half up against twice the root.
  logic             e_valid;
  logic [NUM_W-1:0] e_num;
  logic [DEN_W-1:0] e_den;
  logic             e_zero;
  tag_t             e_tag;

  logic             vs [Q_W];
  logic [NUM_W-1:0] rems [Q_W];
  logic [DEN_W-1:0] dens [Q_W];
  logic [Q_W-1:0]   qs [Q_W];
  logic             zs [Q_W];
  tag_t             ts [Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_num  <= {1'b0, in_tag.prod} + NUM_W'(in_root);
      e_den  <= {in_root, 1'b0};
      e_zero <= (in_root == '0);
      e_tag  <= in_tag;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             vi;
    logic [NUM_W-1:0] remi;
    logic [DEN_W-1:0] deni;
    logic [Q_W-1:0]   qi;
    logic             zi;
    tag_t             ti;
    logic [CMP_W-1:0] shifted;

    if (k == 0) begin : g_first
      assign vi   = e_valid;
      assign remi = e_num;
      assign deni = e_den;
      assign qi   = '0;
      assign zi   = e_zero;
      assign ti   = e_tag;
    end else begin : g_next
      assign vi   = vs[k-1];
      assign remi = rems[k-1];
      assign deni = dens[k-1];
      assign qi   = qs[k-1];
      assign zi   = zs[k-1];
      assign ti   = ts[k-1];
    end

    assign shifted = CMP_W'(deni) << (Q_W - 1 - k);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dens[k] <= deni;
        zs[k]   <= zi;
        ts[k]   <= ti;
        if (CMP_W'(remi) >= shifted) begin
          rems[k] <= remi - shifted[NUM_W-1:0];
          qs[k]   <= qi | (Q_W'(1) << (Q_W - 1 - k));
        end else begin
          rems[k] <= remi;
          qs[k]   <= qi;
        end
      end
    end
  end

  assign out_valid = vs[Q_W-1];
  assign out_q     = qs[Q_W-1];
  assign out_zero  = zs[Q_W-1];
  assign out_tag   = ts[Q_W-1];

endmodule

FILE: src/apu_value_stage.sv
`include "adagrad_parameter_update_unit_macros.svh"

module apu_value_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [apu_pkg::Q_W-1:0]   in_q,
  input  logic                      in_zero,
  input  apu_pkg::tag_t             in_tag,
  output logic                      en,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic [apu_pkg::IDX_W-1:0] m_idx,
  output logic [apu_pkg::VAL_W-1:0] m_value,
  output logic                      m_sat
);
  import apu_pkg::*;

  logic [VAL_W-1:0] val_mem [NUM_VARS];

  logic             vw_valid;
  logic             vw_load;
  logic [IDX_W-1:0] vw_idx;
  logic             vw_neg;
  logic [VAL_W-1:0] vw_init;
  logic             vw_sat;
  logic [Q_W-1:0]   vw_q;
  logic             vw_zero;
  logic [VAL_W-1:0] rdata;
  logic             hit;
  logic [VAL_W-1:0] hit_val;

  logic [VAL_W-1:0]        base;
  logic signed [VAL_W+1:0] delta;
  logic signed [VAL_W+1:0] total;
  logic                    clip_hi;
  logic                    clip_lo;
  logic [VAL_W-1:0]        v_new;
  logic                    sat_new;

  // The pipeline moves unless a finished result is blocked behind a held output.
  assign en = !m_valid || m_ready || !vw_valid;

  assign base  = hit ? hit_val : rdata;
  assign delta = vw_zero ? '0 :
                 (vw_neg ? -$signed({2'b00, {(VAL_W-Q_W){1'b0}}, vw_q})
                         :  $signed({2'b00, {(VAL_W-Q_W){1'b0}}, vw_q}));
  assign total   = $signed({{2{base[VAL_W-1]}}, base}) + delta;
  assign clip_hi = total > $signed((VAL_W+2)'({1'b0, {(VAL_W-1){1'b1}}}));
  assign clip_lo = total < -$signed((VAL_W+2)'({1'b1, {(VAL_W-1){1'b0}}}));

  always_comb begin
    if (vw_load) begin
      v_new   = vw_init;
      sat_new = 1'b0;
    end else begin
      if (clip_hi) begin
        v_new = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (clip_lo) begin
        v_new = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        v_new = total[VAL_W-1:0];
      end
      sat_new = vw_sat || clip_hi || clip_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vw_valid <= 1'b0;
      hit      <= 1'b0;
    end else if (en) begin
      vw_valid <= in_valid;
      hit      <= vw_valid && in_valid && (vw_idx == in_tag.idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vw_load <= in_tag.load;
      vw_idx  <= in_tag.idx;
      vw_neg  <= in_tag.neg;
      vw_init <= in_tag.init;
      vw_sat  <= in_tag.sat;
      vw_q    <= in_q;
      vw_zero <= in_zero;
      rdata   <= val_mem[in_tag.idx];
      hit_val <= v_new;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vw_valid) begin
      val_mem[vw_idx] <= v_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en && vw_valid) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vw_valid) begin
      m_idx   <= vw_idx;
      m_value <= v_new;
      m_sat   <= sat_new;
    end
  end

  `APU_ASSERT(a_hit_has_item, hit |-> vw_valid, "forwarding hit without an item")
  `APU_ASSERT_NEXT(a_result_taken, en && vw_valid, m_valid, "finished item not presented")
  `APU_ASSERT(a_empty_flows, !m_valid |-> en, "pipeline stalled with empty output")

endmodule

FILE: src/adagrad_parameter_update_unit.sv
// Adagrad parameter update for 1024 variables: takes one item per clock while the output is
// not held and returns one result per item, in order. The pipeline holds the 32-stage square
// root and the 18-stage divider; the accumulator and value memories are each read and written
// once per cycle while the pipeline moves, with forwarding between neighboring items on the
// same variable. Memory contents are undefined after reset, so load a variable before updating it.
module adagrad_parameter_update_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] var_index, [33:10] gradient, [65:34] initial_value, [71:66] zero
  input  logic [71:0]                       s_axis_tdata,
  // [0] mode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] out_index, [41:10] new_value, [47:42] zero
  output logic [47:0]                       m_axis_tdata,
  // [0] saturated
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [apu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import apu_pkg::*;

  logic [LR_W-1:0]  learning_rate;
  logic [EPS_W-1:0] stability_offset;
  logic             en;

  logic             sum_valid;
  logic [RAD_W-1:0] sum_rad;
  tag_t             sum_tag;
  logic             root_valid;
  logic [ROOT_W-1:0] root;
  tag_t             root_tag;
  logic             div_valid;
  logic [Q_W-1:0]   div_q;
  logic             div_zero;
  tag_t             div_tag;
  logic [IDX_W-1:0] res_idx;
  logic [VAL_W-1:0] res_value;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate    <= LR_RESET;
      stability_offset <= EPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEARNING_RATE:    learning_rate    <= cfg_data;
        REG_STABILITY_OFFSET: stability_offset <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  apu_sum_stage u_sum (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (s_axis_tvalid && en),
    .in_load          (s_axis_tuser == MODE_LOAD),
    .in_idx           (s_axis_tdata[9:0]),
    .in_grad          (s_axis_tdata[33:10]),
    .in_init          (s_axis_tdata[65:34]),
    .learning_rate    (learning_rate),
    .stability_offset (stability_offset),
    .out_valid        (sum_valid),
    .out_rad          (sum_rad),
    .out_tag          (sum_tag)
  );

  apu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sum_valid),
    .in_rad    (sum_rad),
    .in_tag    (sum_tag),
    .out_valid (root_valid),
    .out_root  (root),
    .out_tag   (root_tag)
  );

  apu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in_root   (root),
    .in_tag    (root_tag),
    .out_valid (div_valid),
    .out_q     (div_q),
    .out_zero  (div_zero),
    .out_tag   (div_tag)
  );

  apu_value_stage u_value (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .in_q     (div_q),
    .in_zero  (div_zero),
    .in_tag   (div_tag),
    .en       (en),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_idx    (res_idx),
    .m_value  (res_value),
    .m_sat    (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, res_value, res_idx};

endmodule

FILE: test/tb_adagrad_parameter_update_unit.sv
`timescale 1ns / 1ps

module tb_adagrad_parameter_update_unit;
  import apu_pkg::*;

  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 1;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic             sat;
  } update_result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adagrad_parameter_update_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Shadow copy of the block's state and registers.
  logic [SUM_W-1:0] sum_shadow [NUM_VARS];
  logic [VAL_W-1:0] value_shadow [NUM_VARS];
  bit               loaded [NUM_VARS];
  longint unsigned  eta = LR_RESET;
  longint unsigned  epsilon = EPS_RESET;

  update_result_t pending_results[$];
  int  failures = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  sat_seen = 0;
  bit  quiet = 0;
  bit  hold_request = 0;

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic predict_item(input logic mode, input logic [IDX_W-1:0] idx,
                              input logic [GRAD_W-1:0] grad, input logic [VAL_W-1:0] init);
    longint signed gs, v, delta;
    longint unsigned mag, s, root, q;
    update_result_t r;
    r.idx = idx;
    r.sat = 0;
    if (mode == MODE_LOAD) begin
      value_shadow[idx] = init;
      sum_shadow[idx] = '0;
      loaded[idx] = 1;
      r.value = init;
    end else begin
      gs = longint'($signed(grad));
      mag = (gs < 0) ? longint'(-gs) : longint'(gs);
      s = longint'(sum_shadow[idx]) + mag * mag;
      if (s > SUM_LIMIT) begin
        s = SUM_LIMIT;
        r.sat = 1;
      end
      sum_shadow[idx] = s[SUM_W-1:0];
      root = isqrt((s + epsilon) << 14);
      delta = 0;
      if (root != 0) begin
        q = (eta * mag + root) / (root * 2);
        delta = (gs < 0) ? -longint'(q) : longint'(q);
      end
      v = longint'($signed(value_shadow[idx])) + delta;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        r.sat = 1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        r.sat = 1;
      end
      value_shadow[idx] = v[VAL_W-1:0];
      r.value = v[VAL_W-1:0];
    end
    pending_results.push_back(r);
  endtask

  task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                           input logic [GRAD_W-1:0] grad, input logic [VAL_W-1:0] init);
    bit taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {6'd0, init, grad, idx};
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    predict_item(mode, idx, grad, init);
    items_sent++;
  endtask

  // Lets every expected result arrive, then gives the pipeline time to settle.
  task automatic drain;
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high after the transfer; the caller drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    if (idx == REG_LEARNING_RATE) eta = data[LR_W-1:0];
    else epsilon = data[EPS_W-1:0];
  endtask

  task automatic set_rates(input logic [LR_W-1:0] lr, input logic [EPS_W-1:0] eps);
    drain();
    write_reg(REG_LEARNING_RATE, CFG_DATA_W'(lr));
    write_reg(REG_STABILITY_OFFSET, CFG_DATA_W'(eps));
    cfg_valid <= 0;
  endtask

  function automatic logic [GRAD_W-1:0] pick_gradient;
    case ($urandom_range(0, 5))
      0: return GRAD_W'($urandom_range(0, 255));
      1: return -GRAD_W'($urandom_range(0, 255));
      2: return {1'b0, {(GRAD_W-1){1'b1}}};
      3: return {1'b1, {(GRAD_W-1){1'b0}}};
      default: return GRAD_W'($urandom);
    endcase
  endfunction

  // Mostly updates after a first load, half of them on a small set of variables so that
  // back-to-back items on one variable and long accumulations are common.
  task automatic random_items(input int count);
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] init;
    repeat (count) begin
      idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
      init = ($urandom_range(0, 2) == 0) ? VAL_W'($urandom_range(0, 1 << 20)) : $urandom;
      if (!loaded[idx] || $urandom_range(0, 6) == 0)
        send_item(MODE_LOAD, idx, GRAD_W'($urandom), init);
      else
        send_item(MODE_UPDATE, idx, pick_gradient(), VAL_W'($urandom));
    end
  endtask

  task automatic test_field_extremes;
    send_item(MODE_LOAD, 10'd0, 24'd0, 32'h8000_0000);
    send_item(MODE_LOAD, 10'd1023, 24'hFF_FFFF, 32'h7FFF_FFFF);
    send_item(MODE_LOAD, 10'd1, 24'd0, 32'd0);
    send_item(MODE_UPDATE, 10'd1, 24'h7F_FFFF, 32'd0);
    send_item(MODE_UPDATE, 10'd1, 24'h80_0000, 32'hFFFF_FFFF);
    send_item(MODE_UPDATE, 10'd1, 24'd0, 32'd0);
    send_item(MODE_UPDATE, 10'd0, 24'hFF_FFFF, 32'd0);
    send_item(MODE_UPDATE, 10'd1023, 24'd1, 32'd0);
  endtask

  task automatic test_sum_saturation;
    send_item(MODE_LOAD, 10'd5, 24'd0, 32'd100);
    repeat (6) send_item(MODE_UPDATE, 10'd5, 24'h80_0000, 32'd0);
  endtask

  task automatic test_value_saturation_and_zero_root;
    set_rates({LR_W{1'b1}}, 16'd0);
    send_item(MODE_LOAD, 10'd6, 24'd0, 32'h7FFF_FFF0);
    send_item(MODE_UPDATE, 10'd6, 24'h7F_FFFF, 32'd0);
    send_item(MODE_LOAD, 10'd7, 24'd0, 32'h8000_0010);
    send_item(MODE_UPDATE, 10'd7, 24'h80_0000, 32'd0);
    // A zero accumulator and a zero offset give a zero root, so the value stays.
    send_item(MODE_LOAD, 10'd8, 24'd0, 32'd12345);
    send_item(MODE_UPDATE, 10'd8, 24'd0, 32'd0);
    send_item(MODE_UPDATE, 10'd8, 24'd3, 32'd0);
  endtask

  task automatic test_output_backpressure;
    set_rates(24'd4_000_000, 16'd65535);
    hold_request = 1;
    random_items(300);
  endtask

  always @(posedge clk) begin
    update_result_t r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer idx=%0d", m_axis_tdata[9:0]);
        failures++;
      end else begin
        r = pending_results.pop_front();
        results_seen++;
        if (m_axis_tuser) sat_seen++;
        if (m_axis_tdata[9:0] !== r.idx) begin
          $error("out_index expected %0d actual %0d", r.idx, m_axis_tdata[9:0]);
          failures++;
        end
        if (m_axis_tdata[41:10] !== r.value) begin
          $error("new_value expected %0d actual %0d", $signed(r.value),
                 $signed(m_axis_tdata[41:10]));
          failures++;
        end
        if (m_axis_tuser !== r.sat) begin
          $error("saturated expected %0d actual %0d", r.sat, m_axis_tuser);
          failures++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk);
        hold_request = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_axis_tready <= 1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_field_extremes();
    test_sum_saturation();
    random_items(250);
    test_value_saturation_and_zero_root();
    set_rates(24'd0, 16'd65535);
    random_items(150);
    set_rates(LR_W'($urandom), EPS_W'($urandom));
    random_items(250);
    test_output_backpressure();
    set_rates(LR_RESET, EPS_RESET);
    quiet = 1;
    random_items(250);
    drain();
    $display("Sent %0d items and checked %0d results, %0d of them saturated,",
             items_sent, results_seen, sat_seen);
    $display("across five register settings with random and long output stalls.");
    if (failures == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/apu_pkg.sv
src/apu_sum_stage.sv
src/apu_sqrt.sv
src/apu_div.sv
src/apu_value_stage.sv
src/adagrad_parameter_update_unit.sv
test/tb_adagrad_parameter_update_unit.sv
